FILE: rtl/wto_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared widths, codes, state encoding and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wto_pkg;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 8;
    localparam int ENTRY_W   = 17;
    localparam int SAMPLE_W  = 16;
    localparam int SPP_W     = 16;
    localparam int GAIN_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;
    localparam int MUL_CNT_W = 5;

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(GAIN_W);

    localparam logic [SPP_W-1:0]    SPP_RESET  = 16'd100;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 17'd19661;
    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

FILE: rtl/wto_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/wto_divider.sv
// ----------------------------------------------------------------------------
// Serial table index divider
// Restoring division of position * TABLE_DEPTH by samples per period,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_divider #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [wto_pkg::SPP_W-1:0]          position,
    input  logic [wto_pkg::SPP_W-1:0]          spp,
    output logic [$clog2(TABLE_DEPTH)-1:0]     quotient,
    output wto_pkg::unit_status_t              status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int DW    = wto_pkg::SPP_W + IDX_W;
    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [DW-1:0]                   dividend;
    logic [wto_pkg::SPP_W-1:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]                low_reg, low_next, low_shift;
    logic [wto_pkg::SPP_W-1:0]       spp_reg;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [wto_pkg::SPP_W:0]         trial;
    logic                            qbit;

    assign dividend  = DW'(position) * DW'(TABLE_DEPTH);
    assign trial     = {rem_reg, low_reg[IDX_W-1]};
    assign qbit      = (trial >= {1'b0, spp_reg});
    assign low_shift = low_reg << 1;

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = dividend[DW-1:IDX_W];
            low_next  = dividend[IDX_W-1:0];
            cnt_next  = CNT_W'(IDX_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = qbit ? wto_pkg::SPP_W'(trial - {1'b0, spp_reg})
                            : trial[wto_pkg::SPP_W-1:0];
            low_next = low_shift | IDX_W'(qbit);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        if (start) begin
            spp_reg <= spp;
        end
    end

    assign quotient    = low_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/wto_scaler.sv
// ----------------------------------------------------------------------------
// Serial gain scaler
// Shift-add multiply of the entry magnitude by the gain, one gain bit per
// cycle, then shift right 16 and saturate to a signed 16-bit sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_scaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [wto_pkg::ENTRY_W-1:0] entry,
    input  logic [wto_pkg::GAIN_W-1:0]        gain,
    output logic [wto_pkg::SAMPLE_W-1:0]      sample,
    output wto_pkg::unit_status_t             status
);

    localparam int EW = wto_pkg::ENTRY_W;
    localparam int GW = wto_pkg::GAIN_W;

    logic [EW-1:0]                 mag_reg;
    logic                          neg_reg;
    logic [GW-1:0]                 g_reg;
    logic [EW-1:0]                 hi_reg, hi_next;
    logic [GW-1:0]                 lo_reg, lo_next;
    logic [wto_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [EW:0]                   psum;
    logic [EW:0]                   prod;

    assign psum = {1'b0, hi_reg} + (g_reg[0] ? {1'b0, mag_reg} : '0);

    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = wto_pkg::MUL_STEPS;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            hi_next  = psum[EW:1];
            lo_next  = {psum[0], lo_reg[GW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wto_pkg::MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (start) begin
            neg_reg <= entry[EW-1];
            mag_reg <= entry[EW-1] ? EW'(-entry) : EW'(entry);
            g_reg   <= gain;
        end else if (busy_reg) begin
            g_reg <= g_reg >> 1;
        end
    end

    // Product bits 33:16
    assign prod = {hi_reg, lo_reg[GW-1]};

    always_comb begin
        if (neg_reg) begin
            if (prod >= (EW+1)'(wto_pkg::SAMPLE_NEG_MAX)) begin
                sample = wto_pkg::SAMPLE_NEG_MAX;
            end else begin
                sample = wto_pkg::SAMPLE_W'(-prod[wto_pkg::SAMPLE_W-1:0]);
            end
        end else begin
            if (prod > (EW+1)'(wto_pkg::SAMPLE_POS_MAX)) begin
                sample = wto_pkg::SAMPLE_POS_MAX;
            end else begin
                sample = prod[wto_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: rtl/wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator
// A tick is served in order by a serial index divide, a table read and a serial
// multiply, and m_valid rises once the product is registered at the output.
// s_ready is low from an accepted tick until its result is loaded; other ops complete while idle.
// A result held at the output stalls the next tick and keeps s_ready low.
// Synchronous active-low reset clears position and control and sets period and gain to defaults, not the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavetable_oscillator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [wto_pkg::OP_W-1:0]             s_op,
    input  logic [wto_pkg::ADDR_W-1:0]           s_entry_index,
    input  logic signed [wto_pkg::ENTRY_W-1:0]   s_entry_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wto_pkg::SAMPLE_W-1:0]  m_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wto_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wto_pkg::CFG_W-1:0]            cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SW    = wto_pkg::SPP_W;

    wto_pkg::state_t          state_reg, state_next;
    logic [SW-1:0]            spp_reg;
    logic [wto_pkg::GAIN_W-1:0] gain_reg;
    logic [SW-1:0]            position_reg, position_next;
    logic                     m_valid_reg, m_valid_next;
    logic [wto_pkg::SAMPLE_W-1:0] m_sample_reg;

    logic                     s_fire;
    logic                     tick_fire;
    logic                     write_fire;
    logic [SW-1:0]            spp_eff;
    logic [SW-1:0]            pos_eff;
    logic [SW:0]              pos_inc;
    logic                     out_free;

    logic                     div_start;
    logic                     ram_re;
    logic                     mul_start;
    logic                     out_load;

    logic [IDX_W-1:0]         quotient;
    wto_pkg::unit_status_t    div_status;
    wto_pkg::unit_status_t    mul_status;
    logic [wto_pkg::ENTRY_W-1:0] ram_rdata;
    logic [wto_pkg::SAMPLE_W-1:0] mul_sample;

    assign s_fire     = s_valid && s_ready;
    assign tick_fire  = s_fire && (s_op == wto_pkg::OP_TICK);
    assign write_fire = s_fire && (s_op == wto_pkg::OP_WRITE)
                        && (32'(s_entry_index) < TABLE_DEPTH);
    assign out_free   = !m_valid_reg || m_ready;

    assign spp_eff = (spp_reg == '0) ? SW'(1) : spp_reg;
    assign pos_eff = (position_reg >= spp_eff) ? '0 : position_reg;
    assign pos_inc = {1'b0, pos_eff} + 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wto_pkg::ST_IDLE: begin
                if (tick_fire) begin
                    state_next = wto_pkg::ST_DIV;
                end
            end
            wto_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = wto_pkg::ST_READ;
                end
            end
            wto_pkg::ST_READ: begin
                state_next = wto_pkg::ST_MUL;
            end
            wto_pkg::ST_MUL: begin
                if (mul_status.done && out_free) begin
                    state_next = wto_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wto_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        ram_re    = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            wto_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = tick_fire;
            end
            wto_pkg::ST_DIV: begin
                ram_re = div_status.done;
            end
            wto_pkg::ST_READ: begin
                mul_start = 1'b1;
            end
            wto_pkg::ST_MUL: begin
                out_load = mul_status.done && out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        position_next = position_reg;
        if (s_fire) begin
            case (s_op)
                wto_pkg::OP_TICK: begin
                    position_next = (pos_inc >= {1'b0, spp_eff}) ? '0 : pos_inc[SW-1:0];
                end
                wto_pkg::OP_RESTART: begin
                    position_next = '0;
                end
                default: begin
                    position_next = position_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wto_pkg::ST_IDLE;
            spp_reg      <= wto_pkg::SPP_RESET;
            gain_reg     <= wto_pkg::GAIN_RESET;
            position_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wto_pkg::CFG_SPP:  spp_reg  <= cfg_data[SW-1:0];
                    wto_pkg::CFG_GAIN: gain_reg <= cfg_data[wto_pkg::GAIN_W-1:0];
                    default: begin
                        spp_reg <= spp_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_reg <= mul_sample;
        end
    end

    wto_ram #(
        .WIDTH (wto_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (write_fire),
        .waddr (IDX_W'(s_entry_index)),
        .wdata (s_entry_value),
        .re    (ram_re),
        .raddr (quotient),
        .rdata (ram_rdata)
    );

    wto_divider #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .position (pos_eff),
        .spp      (spp_eff),
        .quotient (quotient),
        .status   (div_status)
    );

    wto_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .entry   (ram_rdata),
        .gain    (gain_reg),
        .sample  (mul_sample),
        .status  (mul_status)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

endmodule

FILE: rtl/wto_checker.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator port checker
// Temporal checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wto_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [wto_pkg::OP_W-1:0]            s_op,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [wto_pkg::SAMPLE_W-1:0] m_sample
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample))
        else $error("stalled result changed");

    // Drop results on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A tick transaction occupies the block
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == wto_pkg::OP_TICK |=> !s_ready)
        else $error("input ready right after tick");

    // Other ops create no result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op != wto_pkg::OP_TICK && !m_valid |=> !m_valid)
        else $error("result without tick");

endmodule

bind wavetable_oscillator wto_checker u_wto_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_op     (s_op),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_sample (m_sample)
);

FILE: bench/wavetable_checker.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator checker
// Watches the input, result and register channels of the oscillator, keeps a
// cycle-free copy of its position, table and registers, queues the sample each
// accepted tick should produce and compares every accepted result against the
// oldest queued sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavetable_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [wto_pkg::OP_W-1:0]             s_op,
    input  logic [wto_pkg::ADDR_W-1:0]           s_entry_index,
    input  logic signed [wto_pkg::ENTRY_W-1:0]   s_entry_value,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [wto_pkg::SAMPLE_W-1:0]  m_sample,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [wto_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wto_pkg::CFG_W-1:0]            cfg_data,
    output int                                   mismatch_count,
    output int                                   pending_samples,
    output int                                   checked_samples
);

    localparam int DEPTH = 256;
    localparam int EW    = wto_pkg::ENTRY_W;
    localparam int PW    = wto_pkg::ENTRY_W + wto_pkg::GAIN_W + 1;

    logic [wto_pkg::SPP_W-1:0]           period;
    logic [wto_pkg::GAIN_W-1:0]          gain_q16;
    int unsigned                         phase_pos;
    logic signed [wto_pkg::ENTRY_W-1:0]  wave_entries [DEPTH];
    logic signed [wto_pkg::SAMPLE_W-1:0] expected_samples [$];
    logic signed [wto_pkg::SAMPLE_W-1:0] want;
    int unsigned                         eff_period;
    int unsigned                         lookup;
    int                                  errs;
    int                                  seen;

    function automatic logic signed [wto_pkg::SAMPLE_W-1:0] scaled_sample(
        input logic signed [wto_pkg::ENTRY_W-1:0] entry,
        input logic [wto_pkg::GAIN_W-1:0]         g
    );
        logic signed [EW:0] wide;
        logic [EW:0]        mag;
        logic [PW-1:0]      prod;
        wide = entry;
        mag  = (wide < 0) ? (EW+1)'(-wide) : (EW+1)'(wide);
        prod = PW'(mag) * PW'(g);
        prod = prod >> 16;
        if (wide < 0) begin
            if (prod > 32768)
                return wto_pkg::SAMPLE_NEG_MAX;
            return wto_pkg::SAMPLE_W'(PW'(0) - prod);
        end
        if (prod > 32767)
            return wto_pkg::SAMPLE_POS_MAX;
        return wto_pkg::SAMPLE_W'(prod);
    endfunction

    initial begin
        errs = 0;
        seen = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            period    = wto_pkg::SPP_RESET;
            gain_q16  = wto_pkg::GAIN_RESET;
            phase_pos = 0;
            expected_samples.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample: no result expected, actual %0d", m_sample);
                    errs++;
                end else begin
                    want = expected_samples.pop_front();
                    seen++;
                    if (m_sample !== want) begin
                        $error("sample: expected %0d, actual %0d", want, m_sample);
                        errs++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wto_pkg::CFG_SPP:  period   = cfg_data[wto_pkg::SPP_W-1:0];
                    wto_pkg::CFG_GAIN: gain_q16 = cfg_data[wto_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                case (s_op)
                    wto_pkg::OP_WRITE: begin
                        wave_entries[s_entry_index] = s_entry_value;
                    end
                    wto_pkg::OP_RESTART: begin
                        phase_pos = 0;
                    end
                    wto_pkg::OP_TICK: begin
                        eff_period = (period == 0) ? 1 : period;
                        if (phase_pos >= eff_period)
                            phase_pos = 0;
                        lookup = (phase_pos * DEPTH) / eff_period;
                        if (lookup >= DEPTH)
                            lookup = DEPTH - 1;
                        expected_samples.push_back(
                            scaled_sample(wave_entries[lookup], gain_q16));
                        phase_pos++;
                        if (phase_pos >= eff_period)
                            phase_pos = 0;
                    end
                    default: ;
                endcase
            end
        end
        pending_samples <= expected_samples.size();
        mismatch_count  <= errs;
        checked_samples <= seen;
    end

endmodule

FILE: bench/tb_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator testbench
// Loads the whole wave table, runs a directed pass over gain and period
// extremes, saturation, restart, the unused op and a period lowered below the
// current position, then random phases with mixed idling on both channels and
// one long output stall. A separate checker predicts and compares samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wavetable_oscillator;

    localparam logic [wto_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int  NUM_PHASES      = 8;
    localparam int  ITEMS_PER_PHASE = 180;
    localparam int  SETTLE_CYCLES   = 40;
    localparam int  LONG_HOLD       = 400;
    localparam int  TIMEOUT_NS      = 40_000_000;

    logic                                 aclk          = 1'b0;
    logic                                 aresetn       = 1'b0;
    logic                                 s_valid       = 1'b0;
    logic                                 s_ready;
    logic [wto_pkg::OP_W-1:0]             s_op          = wto_pkg::OP_WRITE;
    logic [wto_pkg::ADDR_W-1:0]           s_entry_index = '0;
    logic signed [wto_pkg::ENTRY_W-1:0]   s_entry_value = '0;
    logic                                 m_valid;
    logic                                 m_ready       = 1'b0;
    logic signed [wto_pkg::SAMPLE_W-1:0]  m_sample;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [wto_pkg::CFG_IDX_W-1:0]        cfg_index     = wto_pkg::CFG_SPP;
    logic [wto_pkg::CFG_W-1:0]            cfg_data      = '0;

    int mismatch_count;
    int pending_samples;
    int checked_samples;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int ticks_sent     = 0;
    int reg_writes     = 0;

    wavetable_oscillator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    wavetable_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_entry_index   (s_entry_index),
        .s_entry_value   (s_entry_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_samples (pending_samples),
        .checked_samples (checked_samples)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(
        input logic [wto_pkg::OP_W-1:0]           op,
        input logic [wto_pkg::ADDR_W-1:0]         idx,
        input logic signed [wto_pkg::ENTRY_W-1:0] val
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_entry_index <= idx;
        s_entry_value <= val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == wto_pkg::OP_TICK)
            ticks_sent++;
    endtask

    task automatic random_item();
        int roll;
        logic signed [wto_pkg::ENTRY_W-1:0] val;
        roll = $urandom_range(99);
        val  = wto_pkg::ENTRY_W'($urandom());
        if ($urandom_range(15) == 0)
            val = ($urandom_range(1) == 1) ? wto_pkg::ENTRY_W'(32768)
                                           : -wto_pkg::ENTRY_W'(32768);
        if (roll < 70)
            send_item(wto_pkg::OP_TICK, wto_pkg::ADDR_W'($urandom()), val);
        else if (roll < 88)
            send_item(wto_pkg::OP_WRITE, wto_pkg::ADDR_W'($urandom()), val);
        else if (roll < 95)
            send_item(wto_pkg::OP_RESTART, wto_pkg::ADDR_W'($urandom()), val);
        else
            send_item(OP_UNUSED, wto_pkg::ADDR_W'($urandom()), val);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(
        input logic [wto_pkg::SPP_W-1:0]  spp,
        input logic [wto_pkg::GAIN_W-1:0] g
    );
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= wto_pkg::CFG_SPP;
        cfg_data  <= wto_pkg::CFG_W'(spp);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= wto_pkg::CFG_GAIN;
        cfg_data  <= wto_pkg::CFG_W'(g);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes += 2;
        @(posedge aclk);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [wto_pkg::SPP_W-1:0]  spp;
        logic [wto_pkg::GAIN_W-1:0] g;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 256; i++)
            send_item(wto_pkg::OP_WRITE, wto_pkg::ADDR_W'(i), wto_pkg::ENTRY_W'($urandom()));

        send_item(wto_pkg::OP_WRITE, 8'd0, wto_pkg::ENTRY_W'(32768));
        send_item(wto_pkg::OP_WRITE, 8'd2, -wto_pkg::ENTRY_W'(32768));
        send_item(wto_pkg::OP_WRITE, 8'd5, wto_pkg::ENTRY_W'(65535));
        send_item(wto_pkg::OP_WRITE, 8'd7, wto_pkg::ENTRY_W'(-65536));
        send_item(wto_pkg::OP_RESTART, 8'd255, wto_pkg::ENTRY_W'(-1));
        repeat (4) send_item(wto_pkg::OP_TICK, 8'd0, '0);
        send_item(OP_UNUSED, 8'd255, wto_pkg::ENTRY_W'(65535));
        send_item(wto_pkg::OP_TICK, 8'd128, wto_pkg::ENTRY_W'(-65536));
        send_item(wto_pkg::OP_RESTART, 8'd0, '0);
        send_item(wto_pkg::OP_TICK, 8'd0, '0);

        configure(16'd1, 17'd65536);
        send_item(wto_pkg::OP_TICK, 8'd0, '0);
        send_item(wto_pkg::OP_WRITE, 8'd0, -wto_pkg::ENTRY_W'(32768));
        send_item(wto_pkg::OP_TICK, 8'd0, '0);
        configure(16'd0, 17'd131071);
        send_item(wto_pkg::OP_TICK, 8'd0, '0);
        send_item(wto_pkg::OP_WRITE, 8'd0, wto_pkg::ENTRY_W'(-65536));
        send_item(wto_pkg::OP_TICK, 8'd0, '0);
        configure(16'd200, 17'd0);
        repeat (6) send_item(wto_pkg::OP_TICK, 8'd0, '0);
        configure(16'd4, 17'd32768);
        send_item(wto_pkg::OP_TICK, 8'd0, '0);
        configure(16'd65535, 17'd65535);
        send_item(wto_pkg::OP_TICK, 8'd0, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: spp = 16'd64;
                1: spp = 16'd256;
                2: spp = 16'd3;
                3: spp = 16'd1;
                4: spp = wto_pkg::SPP_W'($urandom_range(2, 400));
                5: spp = 16'd0;
                6: spp = 16'd65535;
                default: spp = wto_pkg::SPP_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(4))
                0: g = 17'd0;
                1: g = 17'd65536;
                2: g = 17'd131071;
                3: g = wto_pkg::GAIN_RESET;
                default: g = wto_pkg::GAIN_W'($urandom_range(0, 131071));
            endcase
            configure(spp, g);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 4)
                hold_request <= hold_request + 1;
            repeat (ITEMS_PER_PHASE) random_item();
        end

        drain();

        $display("covered: %0d input transactions (%0d ticks), %0d register writes, %0d samples",
                 items_sent, ticks_sent, reg_writes, checked_samples);
        $display("covered: saturation, zero and full periods, gain to 131071, idle mixes, long stall");
        if (mismatch_count == 0 && pending_samples == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
